// ===== sv/ftpd_pkg.sv =====
// ftpd_pkg: shared types and constants for the flight touchdown phase detector
// no dependencies; imported by every module of the block
`default_nettype none

package ftpd_pkg;

  // time step limits and unit conversion
  localparam int unsigned DtMinUs  = 500;
  localparam int unsigned DtMaxUs  = 10000;
  localparam int unsigned UsPerMs  = 1000;
  localparam int unsigned DtW      = 14;   // clamped step fits 14 bits
  localparam int unsigned HoldW    = 24;
  localparam int unsigned HoldThrW = 20;   // 1023 * 1000 fits 20 bits
  localparam int unsigned FlightW  = 32;
  localparam int unsigned ToutThrW = 26;   // 65535 * 1000 fits 26 bits

  // stream word widths
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RETRACT_SPEED = 3'd0,
    REG_LENGTH_LIMIT  = 3'd1,
    REG_PEAK_MINIMUM  = 3'd2,
    REG_PEAK_DROP     = 3'd3,
    REG_HOLD_MS       = 3'd4,
    REG_TIMEOUT_MS    = 3'd5
  } ftpd_reg_e;

  // sequence phase
  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_AIR    = 2'd1,
    PH_RETURN = 2'd2,
    PH_FAILED = 2'd3
  } ftpd_phase_e;

  // configuration seen by the leg lanes and the phase logic
  typedef struct packed {
    logic signed [15:0]    retract_speed;
    logic        [15:0]    length_limit;
    logic signed [15:0]    peak_minimum;
    logic        [15:0]    peak_drop;
    logic [HoldThrW-1:0]   hold_thr;
    logic [ToutThrW-1:0]   timeout_thr;
  } ftpd_cfg_t;

  // control from the phase logic to each lane
  typedef struct packed {
    logic rearm;   // return lane state to reset
    logic tick;    // accepted tick word
    logic fresh;   // phase is init: lane state reads as zero
    logic active;  // phase after init handling is air
  } ftpd_lane_ctl_t;

  // one result word, phase in the low bits
  typedef struct packed {
    logic        right_landed;
    logic        left_landed;
    logic        failed;
    logic        finished;
    ftpd_phase_e phase;
  } ftpd_res_t;

  // setting for the default reset values of the thresholds
  localparam logic [HoldThrW-1:0] HoldThrRst = HoldThrW'(20 * UsPerMs);
  localparam logic [ToutThrW-1:0] ToutThrRst = ToutThrW'(1500 * UsPerMs);

endpackage

`default_nettype wire

// ===== sv/ftpd_leg.sv =====
// ftpd_leg: one leg lane, tracks peak rate, landing hold time and touchdown mark
// depends on ftpd_pkg
`default_nettype none

module ftpd_leg import ftpd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ftpd_cfg_t          cfg_i,
  input  wire ftpd_lane_ctl_t     ctl_i,
  input  wire logic [15:0]        length_i,
  input  wire logic signed [15:0] rate_i,
  input  wire logic [DtW-1:0]     dt_i,
  output      logic               mark_o
);

  logic signed [15:0] peak_q, peak_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic               mark_q, mark_d;

  logic signed [15:0] peak_cur;
  logic [HoldW-1:0]   hold_cur;
  logic               mark_cur;
  logic [16:0]        drop_amt;
  logic [HoldW:0]     hold_sum;
  logic               reversed, dropped;

  // state as seen by this tick, zero on the first tick after init
  assign peak_cur = ctl_i.fresh ? 16'sd0 : peak_q;
  assign hold_cur = ctl_i.fresh ? '0 : hold_q;
  assign mark_cur = ctl_i.fresh ? 1'b0 : mark_q;

  // peak tracking and landing conditions
  always_comb begin
    peak_d   = (rate_i > peak_cur) ? rate_i : peak_cur;
    reversed = rate_i < cfg_i.retract_speed;
    drop_amt = 17'({peak_d[15], peak_d} - {rate_i[15], rate_i});
    dropped  = (length_i < cfg_i.length_limit) && (peak_d > cfg_i.peak_minimum) &&
               (drop_amt > {1'b0, cfg_i.peak_drop});
    hold_sum = {1'b0, hold_cur} + (HoldW + 1)'(dt_i);
    if (!mark_cur && (reversed || dropped)) begin
      hold_d = hold_sum[HoldW] ? '1 : hold_sum[HoldW-1:0];
    end else begin
      hold_d = '0;
    end
    mark_d = mark_cur | (hold_d >= HoldW'(cfg_i.hold_thr));
  end

  // lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      hold_q <= '0;
      mark_q <= 1'b0;
    end else if (ctl_i.rearm) begin
      peak_q <= '0;
      hold_q <= '0;
      mark_q <= 1'b0;
    end else if (ctl_i.tick && ctl_i.active) begin
      peak_q <= peak_d;
      hold_q <= hold_d;
      mark_q <= mark_d;
    end
  end

  // mark reported for this tick
  assign mark_o = ctl_i.active ? mark_d : mark_q;

endmodule

`default_nettype wire

// ===== sv/ftpd_phase.sv =====
// ftpd_phase: merges the lane marks, keeps flight time and the phase sequence
// depends on ftpd_pkg
`default_nettype none

module ftpd_phase import ftpd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                rearm_i,
  input  wire logic [DtW-1:0]      dt_i,
  input  wire logic [ToutThrW-1:0] timeout_thr_i,
  input  wire logic                left_mark_i,
  input  wire logic                right_mark_i,
  output      ftpd_lane_ctl_t      lane_ctl_o,
  output      ftpd_res_t           res_o
);

  ftpd_phase_e        phase_q, phase_d;
  logic [FlightW-1:0] flight_q, flight_d;
  logic [FlightW-1:0] flight_cur;
  logic [FlightW:0]   flight_sum;
  logic               tick, fresh, air;

  assign tick  = accept_i && !rearm_i;
  assign fresh = (phase_q == PH_INIT);
  assign air   = (phase_q == PH_INIT) || (phase_q == PH_AIR);

  // saturating flight time
  always_comb begin
    flight_cur = fresh ? '0 : flight_q;
    flight_sum = {1'b0, flight_cur} + (FlightW + 1)'(dt_i);
    flight_d   = flight_sum[FlightW] ? '1 : flight_sum[FlightW-1:0];
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (air) begin
      if (left_mark_i && right_mark_i) begin
        phase_d = PH_RETURN;
      end else if (flight_d >= FlightW'(timeout_thr_i)) begin
        phase_d = PH_FAILED;
      end else begin
        phase_d = PH_AIR;
      end
    end
  end

  // lane control and result word
  always_comb begin
    lane_ctl_o.rearm  = accept_i && rearm_i;
    lane_ctl_o.tick   = tick;
    lane_ctl_o.fresh  = fresh;
    lane_ctl_o.active = air;
    if (rearm_i) begin
      res_o = '0;
    end else begin
      res_o.phase        = phase_d;
      res_o.finished     = (phase_d == PH_RETURN);
      res_o.failed       = (phase_d == PH_FAILED);
      res_o.left_landed  = left_mark_i;
      res_o.right_landed = right_mark_i;
    end
  end

  // phase and flight time registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_INIT;
      flight_q <= '0;
    end else if (accept_i && rearm_i) begin
      phase_q  <= PH_INIT;
      flight_q <= '0;
    end else if (tick) begin
      phase_q  <= phase_d;
      flight_q <= flight_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/flight_touchdown_phase_detector_top.sv =====
// flight_touchdown_phase_detector_top: config registers, step clamp, two leg
// lanes, phase merge and a two-entry output skid; depends on ftpd_pkg,
// ftpd_leg and ftpd_phase
// an accepted word's result is registered in the output stage, or in the skid entry
// when the master side stalls; throughput: one word per cycle until the skid fills
// the skid entry keeps input ready while one result waits on the master side
// reset: asynchronous active low, clears phase, flight time, lane state and
// the output stage, and loads the default configuration
`default_nettype none

module flight_touchdown_phase_detector_top import ftpd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [15:0]         cfg_wdata_i,
  // input stream
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // left_length, right_length, left_rate, right_rate, step_us
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // command
  input  wire logic                s_axis_tuser_i,
  // result stream
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // phase, finished, failed, left_landed, right_landed, zero pad
  output      logic [OutDataW-1:0] m_axis_tdata_o
);

  ftpd_cfg_t      cfg_q;
  ftpd_lane_ctl_t lane_ctl;
  ftpd_res_t      res;
  ftpd_res_t      out_q, skid_q;
  logic           out_vld_q, skid_vld_q;
  logic           accept, pop;
  logic [15:0]    step_us;
  logic [DtW-1:0] dt;
  logic           left_mark, right_mark;

  // configuration registers, thresholds scaled to microseconds on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retract_speed <= -16'sd410;
      cfg_q.length_limit  <= 16'd19661;
      cfg_q.peak_minimum  <= 16'sd2048;
      cfg_q.peak_drop     <= 16'd1229;
      cfg_q.hold_thr      <= HoldThrRst;
      cfg_q.timeout_thr   <= ToutThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RETRACT_SPEED: cfg_q.retract_speed <= cfg_wdata_i;
        REG_LENGTH_LIMIT:  cfg_q.length_limit  <= cfg_wdata_i;
        REG_PEAK_MINIMUM:  cfg_q.peak_minimum  <= cfg_wdata_i;
        REG_PEAK_DROP:     cfg_q.peak_drop     <= cfg_wdata_i;
        REG_HOLD_MS:
          cfg_q.hold_thr <= HoldThrW'(HoldThrW'(cfg_wdata_i[9:0]) * HoldThrW'(UsPerMs));
        REG_TIMEOUT_MS:
          cfg_q.timeout_thr <= ToutThrW'(ToutThrW'(cfg_wdata_i) * ToutThrW'(UsPerMs));
        default: ;
      endcase
    end
  end

  // handshake
  assign s_axis_tready_o = !skid_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_vld_q && m_axis_tready_i;

  // clamp the time step
  assign step_us = s_axis_tdata_i[79:64];
  always_comb begin
    priority if (step_us < 16'(DtMinUs)) begin
      dt = DtW'(DtMinUs);
    end else if (step_us > 16'(DtMaxUs)) begin
      dt = DtW'(DtMaxUs);
    end else begin
      dt = step_us[DtW-1:0];
    end
  end

  // leg lanes
  ftpd_leg u_leg_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctl_i    (lane_ctl),
    .length_i (s_axis_tdata_i[15:0]),
    .rate_i   (s_axis_tdata_i[47:32]),
    .dt_i     (dt),
    .mark_o   (left_mark)
  );

  ftpd_leg u_leg_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctl_i    (lane_ctl),
    .length_i (s_axis_tdata_i[31:16]),
    .rate_i   (s_axis_tdata_i[63:48]),
    .dt_i     (dt),
    .mark_o   (right_mark)
  );

  // phase merge
  ftpd_phase u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rearm_i       (s_axis_tuser_i),
    .dt_i          (dt),
    .timeout_thr_i (cfg_q.timeout_thr),
    .left_mark_i   (left_mark),
    .right_mark_i  (right_mark),
    .lane_ctl_o    (lane_ctl),
    .res_o         (res)
  );

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q) begin
      out_vld_q <= accept;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || (pop && !skid_vld_q)) begin
      out_q <= res;
    end else if (pop) begin
      out_q <= skid_q;
    end
    if (out_vld_q && !pop && accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for flight_touchdown_phase_detector_top, directed rows then random
// flights under several register settings and idle patterns; depends on ftpd_pkg and the rtl

module tb;
  import ftpd_pkg::*;

  // one input word, command kept beside the packed data fields
  typedef struct packed {
    logic               cmd;
    logic [15:0]        step_us;
    logic signed [15:0] right_rate;
    logic signed [15:0] left_rate;
    logic [15:0]        right_len;
    logic [15:0]        left_len;
  } touch_word_t;

  // per leg tracking state
  typedef struct packed {
    logic signed [15:0] peak;
    logic [23:0]        hold;
    logic               mark;
  } leg_state_t;

  // directed row: a word or a register write
  typedef struct {
    logic        is_cfg;
    ftpd_reg_e   reg_idx;
    logic [15:0] reg_val;
    touch_word_t w;
    logic        typed;
    ftpd_res_t   want;
  } row_t;

  // fields from msb: right_landed, left_landed, failed, finished, phase
  localparam ftpd_res_t RES_IDLE   = '{1'b0, 1'b0, 1'b0, 1'b0, PH_INIT};
  localparam ftpd_res_t RES_AIR    = '{1'b0, 1'b0, 1'b0, 1'b0, PH_AIR};
  localparam ftpd_res_t RES_DONE   = '{1'b1, 1'b1, 1'b0, 1'b1, PH_RETURN};

  localparam int NumSettings = 5;
  localparam int WordsPerSetting = 90;

  // register settings, one row per random phase, register index order
  localparam logic [15:0] SETTING_VALS [NumSettings][6] = '{
    '{16'hFE66, 16'd19661, 16'd2048,  16'd1229,  16'd20,   16'd120},   // defaults, short timeout
    '{16'h8000, 16'd0,     16'h8000,  16'd0,     16'd0,    16'd0},     // low extremes
    '{16'h7FFF, 16'hFFFF,  16'h7FFF,  16'hFFFF,  16'd1000, 16'd60000}, // high extremes
    '{16'h0000, 16'd40000, 16'd100,   16'd300,   16'd7,    16'd90},
    '{16'hF830, 16'd30000, 16'd0,     16'd5000,  16'd3,    16'hFFFF}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // left_length, right_length, left_rate, right_rate, step_us
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  // command
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // phase, finished, failed, left_landed, right_landed, zero pad
  logic [OutDataW-1:0] m_axis_tdata_o;

  flight_touchdown_phase_detector_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register mirror, reset values
  logic signed [15:0] c_retract    = -16'sd410;
  logic [15:0]        c_len_lim    = 16'd19661;
  logic signed [15:0] c_peak_min   = 16'sd2048;
  logic [15:0]        c_peak_drop  = 16'd1229;
  logic [9:0]         c_hold_ms    = 10'd20;
  logic [15:0]        c_timeout_ms = 16'd1500;

  // predicted block state
  ftpd_phase_e st_phase  = PH_INIT;
  logic [31:0] st_flight = '0;
  leg_state_t  st_left   = '0;
  leg_state_t  st_right  = '0;

  ftpd_res_t   expected_q[$];
  row_t        rows[$];
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          burst_req = 0;
  int          burst_left = 0;

  // random flight shaping
  int          flight_ticks = 0;
  int          land_at_left = 4;
  int          land_at_right = 4;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 40)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic void clear_flight();
    st_phase  = PH_INIT;
    st_flight = '0;
    st_left   = '0;
    st_right  = '0;
  endfunction

  // peak tracking, landing test and hold accumulation for one leg
  function automatic leg_state_t advance_leg(leg_state_t st, logic [15:0] len,
                                             logic signed [15:0] rate, logic [13:0] dt);
    leg_state_t nx;
    logic       retracting, dropping;
    logic [24:0] sum;
    nx = st;
    if (rate > nx.peak) nx.peak = rate;
    retracting = rate < c_retract;
    dropping = (len < c_len_lim) && (nx.peak > c_peak_min) &&
               ((longint'(nx.peak) - longint'(rate)) > longint'(c_peak_drop));
    if (!nx.mark && (retracting || dropping)) begin
      sum = {1'b0, nx.hold} + 25'(dt);
      nx.hold = (sum > 25'hFF_FFFF) ? 24'hFF_FFFF : sum[23:0];
    end else begin
      nx.hold = '0;
    end
    if (longint'(nx.hold) >= longint'(c_hold_ms) * UsPerMs) nx.mark = 1'b1;
    return nx;
  endfunction

  // phase sequence for one accepted word
  function automatic ftpd_res_t predict_touchdown(touch_word_t w);
    ftpd_res_t r;
    logic [13:0] dt;
    longint flight_sum;
    if (w.cmd) begin
      clear_flight();
      return RES_IDLE;
    end
    if (w.step_us < DtMinUs) dt = 14'(DtMinUs);
    else if (w.step_us > DtMaxUs) dt = 14'(DtMaxUs);
    else dt = w.step_us[13:0];
    // first tick after init starts a fresh flight
    if (st_phase == PH_INIT) begin
      clear_flight();
      st_phase = PH_AIR;
    end
    flight_sum = longint'(st_flight) + longint'(dt);
    st_flight = (flight_sum > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : flight_sum[31:0];
    if (st_phase == PH_AIR) begin
      st_left  = advance_leg(st_left,  w.left_len,  w.left_rate,  dt);
      st_right = advance_leg(st_right, w.right_len, w.right_rate, dt);
      if (st_left.mark && st_right.mark) st_phase = PH_RETURN;
      else if (longint'(st_flight) >= longint'(c_timeout_ms) * UsPerMs) st_phase = PH_FAILED;
    end
    r.phase        = st_phase;
    r.finished     = (st_phase == PH_RETURN);
    r.failed       = (st_phase == PH_FAILED);
    r.left_landed  = st_left.mark;
    r.right_landed = st_right.mark;
    return r;
  endfunction

  // leg values: climbing before the landing tick, mostly landing after it
  function automatic void pick_leg(input int land_at, output logic [15:0] len,
                                   output logic [15:0] rate);
    int r;
    len  = 16'($urandom);
    rate = 16'($urandom_range(32767));
    if ($urandom_range(99) < 20) begin
      rate = 16'($urandom);
    end else if (flight_ticks >= land_at) begin
      if ($urandom_range(1) == 0 && c_retract > -16'sd32768) begin
        r = -32768 + int'($urandom_range(int'(c_retract) + 32767));
        rate = 16'(r);
      end else begin
        if (c_len_lim != 0) len = 16'($urandom_range(c_len_lim - 1));
        r = -32768 + int'($urandom_range(32768));
        rate = 16'(r);
      end
    end
  endfunction

  function automatic touch_word_t random_word();
    touch_word_t w;
    int unsigned rearm_pct;
    w = touch_word_t'({$urandom, $urandom, $urandom});
    rearm_pct = (st_phase == PH_RETURN || st_phase == PH_FAILED) ? 30 : 4;
    if ($urandom_range(99) < rearm_pct) begin
      w.cmd = 1'b1;
      flight_ticks  = 0;
      land_at_left  = $urandom_range(1, 12);
      land_at_right = $urandom_range(1, 12);
      return w;
    end
    w.cmd = 1'b0;
    flight_ticks++;
    w.step_us = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300, 10500));
    pick_leg(land_at_left,  w.left_len,  w.left_rate);
    pick_leg(land_at_right, w.right_len, w.right_rate);
    return w;
  endfunction

  task automatic add_word(input touch_word_t w, input logic typed, input ftpd_res_t want);
    row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = REG_RETRACT_SPEED;
    r.reg_val = '0;
    r.w       = w;
    r.typed   = typed;
    r.want    = want;
    rows.push_back(r);
  endtask

  task automatic add_cfg(input ftpd_reg_e idx, input logic [15:0] val);
    row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.w       = '0;
    r.typed   = 1'b0;
    r.want    = RES_IDLE;
    rows.push_back(r);
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(input ftpd_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_RETRACT_SPEED: c_retract    = val;
      REG_LENGTH_LIMIT:  c_len_lim    = val;
      REG_PEAK_MINIMUM:  c_peak_min   = val;
      REG_PEAK_DROP:     c_peak_drop  = val;
      REG_HOLD_MS:       c_hold_ms    = val[9:0];
      REG_TIMEOUT_MS:    c_timeout_ms = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(input touch_word_t w, input logic typed, input ftpd_res_t want);
    ftpd_res_t calc;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {w.step_us, w.right_rate, w.left_rate, w.right_len, w.left_len};
    s_axis_tuser_i  <= w.cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    calc = predict_touchdown(w);
    expected_q.push_back(typed ? want : calc);
  endtask

  // stop sending and wait for every result to be checked
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // receiver: random stalls plus requested long hold-offs
  always @(negedge clk_i) begin
    if (burst_req > 0) begin
      burst_left = burst_req;
      burst_req  = 0;
    end
    if (burst_left > 0) begin
      burst_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    ftpd_res_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = ftpd_res_t'(m_axis_tdata_o[5:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("word with nothing expected", m_axis_tdata_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.phase != want.phase) report_mismatch("phase", got.phase, want.phase);
        if (got.finished != want.finished)
          report_mismatch("finished", got.finished, want.finished);
        if (got.failed != want.failed) report_mismatch("failed", got.failed, want.failed);
        if (got.left_landed != want.left_landed)
          report_mismatch("left_landed", got.left_landed, want.left_landed);
        if (got.right_landed != want.right_landed)
          report_mismatch("right_landed", got.right_landed, want.right_landed);
        if (m_axis_tdata_o[7:6] != 2'b00) report_mismatch("pad", m_axis_tdata_o[7:6], 0);
      end
    end
  end

  // watchdog, far beyond the slowest legal run (about 500 words)
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    touch_word_t w;
    logic [15:0] val;
    // directed rows at reset configuration
    // rearm with every ignored field high
    add_word({1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, RES_IDLE);
    // init tick, step below the clamp, nothing landing
    add_word({1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, RES_AIR);
    // largest rates build peaks, largest step
    add_word({1'b0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000}, 1'b0, RES_IDLE);
    // left retracting at the lowest rate, right dropping from its peak
    add_word({1'b0, 16'd10000, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF}, 1'b0, RES_IDLE);
    add_word({1'b0, 16'd10000, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF}, 1'b1, RES_DONE);
    // tick in return only reports
    add_word({1'b0, 16'h0000, 16'h1234, 16'h8765, 16'h00FF, 16'hFF00}, 1'b1, RES_DONE);
    add_word({1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, RES_IDLE);
    // threshold edges: length at and one under limit, rate at and one under retract
    add_word({1'b0, 16'd499, -16'sd411, -16'sd410, 16'd19660, 16'd19661}, 1'b0, RES_IDLE);
    // peak one over and exactly at the minimum, step one over the clamp
    add_word({1'b0, 16'd10001, 16'sd2048, 16'sd2049, 16'd0, 16'd0}, 1'b0, RES_IDLE);
    // drop one over the setting on both legs
    add_word({1'b0, 16'd500, 16'sd818, 16'sd819, 16'd0, 16'd0}, 1'b0, RES_IDLE);
    // zero timeout fails the flight at once
    add_cfg(REG_TIMEOUT_MS, 16'd0);
    add_word({1'b0, 16'd9999, 16'sd100, 16'sd100, 16'hFFFF, 16'hFFFF}, 1'b0, RES_IDLE);
    add_word({1'b0, 16'd10000, 16'h8000, 16'h8000, 16'd0, 16'd0}, 1'b0, RES_IDLE);
    // zero hold marks both legs on the first air tick, ahead of the timeout
    add_cfg(REG_HOLD_MS, 16'd0);
    add_word({1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, RES_IDLE);
    add_word({1'b0, 16'd1000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, RES_DONE);
    add_cfg(REG_HOLD_MS, 16'd20);
    add_cfg(REG_TIMEOUT_MS, 16'd1500);
    add_word({1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, RES_IDLE);
    add_word({1'b0, 16'd10000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, RES_AIR);
    // rearm in the middle of a flight
    add_word({1'b1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b1, RES_IDLE);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed walk
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_word(rows[i].w, rows[i].typed, rows[i].want);
      end
    end
    wait_drained();

    // random flights, one register setting and idle pattern per phase
    for (int p = 0; p < NumSettings; p++) begin
      for (int r = 0; r < 6; r++) begin
        val = SETTING_VALS[p][r];
        if (ftpd_reg_e'(r) == REG_HOLD_MS) val[15:10] = 6'($urandom);
        write_reg(ftpd_reg_e'(r), val);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int n = 0; n < WordsPerSetting; n++) begin
        // long receiver hold-off fills the skid and stalls the input
        if (n == 40) burst_req = 40;
        // sender pause until every result is back
        if (n == 60) wait_drained();
        w = random_word();
        send_word(w, 1'b0, RES_IDLE);
      end
      wait_drained();
    end

    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
